[hw/rtl/btds_pkg.sv]
// ---------------------------------------------------------------------------
// btds_pkg
// shared types and constants for the byte translate / delete / squeeze filter
// ---------------------------------------------------------------------------
package btds_pkg;

    localparam int BYTE_W        = 8;
    localparam int TABLE_DEPTH   = 256;
    localparam int TABLE_ADDR_W  = $clog2(TABLE_DEPTH);
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 1;

    // input item function codes
    localparam logic FUNC_DATA = 1'b0;
    localparam logic FUNC_LOAD = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COMPLEMENT = 2'd0,
        CFG_DELETE     = 2'd1,
        CFG_SQUEEZE    = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic complement_set;
        logic delete_mode;
        logic squeeze_repeats;
    } t_cfg;

    typedef struct packed {
        logic s1_vld;
        logic out_vld;
    } t_flt_status;

endpackage

[hw/rtl/btds_in_if.sv]
// ---------------------------------------------------------------------------
// btds_in_if
// input channel: data bytes and table load transactions
// ---------------------------------------------------------------------------
interface btds_in_if
    import btds_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              func;
    logic [BYTE_W-1:0] byte_value;
    logic [BYTE_W-1:0] map_value;
    logic              set_member;

    modport source (output valid, output func, output byte_value, output map_value,
                    output set_member, input ready);
    modport sink   (input valid, input func, input byte_value, input map_value,
                    input set_member, output ready);
endinterface

[hw/rtl/btds_out_if.sv]
// ---------------------------------------------------------------------------
// btds_out_if
// output channel: emitted bytes
// ---------------------------------------------------------------------------
interface btds_out_if
    import btds_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;

    modport source (output valid, output out_byte, input ready);
    modport sink   (input valid, input out_byte, output ready);
endinterface

[hw/rtl/btds_table.sv]
// ---------------------------------------------------------------------------
// btds_table
// 256-entry translation and membership memory, registered read
// ---------------------------------------------------------------------------
module btds_table
    import btds_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_wr_en,
    input  logic                    i_rd_en,
    input  logic [TABLE_ADDR_W-1:0] i_addr,
    input  logic [BYTE_W-1:0]       i_wr_map,
    input  logic                    i_wr_member,
    output logic [BYTE_W-1:0]       o_rd_map,
    output logic                    o_rd_member
);

    logic [BYTE_W:0]           r_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]    r_written;
    logic [BYTE_W:0]           r_rd_data;
    logic                      r_rd_written;
    logic [TABLE_ADDR_W-1:0]   r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= {i_wr_map, i_wr_member};
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_addr];
            r_rd_addr <= i_addr;
        end
    end

    // per-entry written flags stand in for the identity reset contents
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written    <= '0;
            r_rd_written <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_written[i_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_written <= r_written[i_addr];
            end
        end
    end

    assign o_rd_map    = r_rd_written ? r_rd_data[BYTE_W:1] : BYTE_W'(r_rd_addr);
    assign o_rd_member = r_rd_written ? r_rd_data[0] : 1'b0;

endmodule

[hw/rtl/btds_filter.sv]
// ---------------------------------------------------------------------------
// btds_filter
// decide stage: delete / translate / squeeze, previous byte and output register
// ---------------------------------------------------------------------------
module btds_filter
    import btds_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_data_acc,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic [BYTE_W-1:0] i_rd_map,
    input  logic              i_rd_member,
    input  logic              i_out_ready,
    output logic              o_ready,
    output logic              o_out_valid,
    output logic [BYTE_W-1:0] o_out_byte,
    output t_flt_status       o_status
);

    logic              r_s1_vld;
    logic [BYTE_W-1:0] r_s1_byte;
    logic              r_out_vld;
    logic [BYTE_W-1:0] r_out_byte;
    logic [BYTE_W-1:0] r_prev;

    logic              s1_adv;
    logic              hit;
    logic [BYTE_W-1:0] emit;
    logic              keep;

    assign s1_adv = r_s1_vld && (!r_out_vld || i_out_ready);
    assign hit    = i_rd_member ^ i_cfg.complement_set;
    assign emit   = i_cfg.delete_mode ? r_s1_byte : i_rd_map;
    assign keep   = !(i_cfg.delete_mode && hit)
                 && !(i_cfg.squeeze_repeats && (emit == r_prev));
    assign o_ready = !r_s1_vld || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_prev    <= '0;
        end else begin
            if (i_data_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv && keep) begin
                r_out_vld <= 1'b1;
                r_prev    <= emit;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_data_acc) begin
            r_s1_byte <= i_byte;
        end
        if (s1_adv && keep) begin
            r_out_byte <= emit;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_out_byte       = r_out_byte;
    assign o_status.s1_vld  = r_s1_vld;
    assign o_status.out_vld = r_out_vld;

endmodule

[hw/rtl/byte_translate_delete_squeeze.sv]
// ---------------------------------------------------------------------------
// byte_translate_delete_squeeze
// byte stream filter with a loadable translation and membership table
// ---------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  i_in      in   valid/ready   func, byte_value, map_value, set_member
//  o_out     out  valid/ready   out_byte
//  i_cfg_*   in   write enable  i_cfg_idx, i_cfg_wdata
//
//  one transaction per cycle sustained while o_out.ready is high; a kept data
//  byte reaches o_out through the table read register, then the decide stage
//  into the output register; deleted or squeezed bytes are not emitted
//  load transactions write the table in the cycle they are accepted
//  reset: synchronous; table reads as identity with no members, no clear pass
//  stalls: i_in.ready drops only when the decide stage and output register
//  are both full and o_out.ready is low
// ---------------------------------------------------------------------------
module byte_translate_delete_squeeze
    import btds_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    btds_in_if.sink               i_in,
    btds_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg              r_cfg;
    t_flt_status       flt_status;
    logic              in_ready;
    logic              in_acc;
    logic              data_acc;
    logic              load_acc;
    logic              out_acc;
    logic [BYTE_W-1:0] rd_map;
    logic              rd_member;

    assign in_acc   = i_in.valid && in_ready;
    assign data_acc = in_acc && (i_in.func == FUNC_DATA);
    assign load_acc = in_acc && (i_in.func == FUNC_LOAD);
    assign i_in.ready = in_ready;
    assign out_acc  = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_COMPLEMENT: r_cfg.complement_set  <= i_cfg_wdata[0];
                CFG_DELETE:     r_cfg.delete_mode     <= i_cfg_wdata[0];
                CFG_SQUEEZE:    r_cfg.squeeze_repeats <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    btds_table u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (load_acc),
        .i_rd_en     (data_acc),
        .i_addr      (i_in.byte_value),
        .i_wr_map    (i_in.map_value),
        .i_wr_member (i_in.set_member),
        .o_rd_map    (rd_map),
        .o_rd_member (rd_member)
    );

    btds_filter u_filter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_data_acc  (data_acc),
        .i_byte      (i_in.byte_value),
        .i_rd_map    (rd_map),
        .i_rd_member (rd_member),
        .i_out_ready (o_out.ready),
        .o_ready     (in_ready),
        .o_out_valid (o_out.valid),
        .o_out_byte  (o_out.out_byte),
        .o_status    (flt_status)
    );

    // a data transaction always occupies the decide stage next cycle
    a_data_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        data_acc |=> flt_status.s1_vld)
        else $error("data transaction did not enter decide stage");

    // a load into an empty pipeline produces nothing
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_acc && !flt_status.s1_vld && !flt_status.out_vld) |=> !o_out.valid)
        else $error("load transaction produced an output");

    // back-to-back emitted bytes differ while squeezing
    a_squeeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && $past(out_acc) && r_cfg.squeeze_repeats
            && $past(r_cfg.squeeze_repeats))
        |-> (o_out.out_byte != $past(o_out.out_byte)))
        else $error("repeated byte emitted with squeeze on");

    // ready low means the decide stage and the output register both hold an item
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_ready |-> (flt_status.s1_vld && flt_status.out_vld))
        else $error("input stalled with room in the pipeline");

endmodule
